FILE: src/ccdrbg_pkg.sv
// ----------------------------------------------------------------------------
// ccdrbg_pkg
// Shared types and constants of the ChaCha20 random generator engine.
// ----------------------------------------------------------------------------
package ccdrbg_pkg;

    typedef logic [31:0] word_t;

    // ChaCha20 block constants, words 0..3 of the initial state
    localparam word_t SIGMA0 = 32'h61707865;
    localparam word_t SIGMA1 = 32'h3320646e;
    localparam word_t SIGMA2 = 32'h79622d32;
    localparam word_t SIGMA3 = 32'h6b206574;

    // mix domain tag bytes, XORed into block bytes 44..46
    localparam logic [7:0] TAG_B0 = 8'h57;
    localparam logic [7:0] TAG_B1 = 8'h4F;
    localparam logic [7:0] TAG_B2 = 8'h53;

    // ten double rounds, eight quarter rounds each, two halves each
    localparam int unsigned DOUBLE_ROUNDS = 10;
    localparam int unsigned ROUND_STEPS   = DOUBLE_ROUNDS * 16;
    localparam int unsigned MAX_CHUNK     = 32;

    typedef enum logic [1:0] {
        CMD_SEED    = 2'd0,
        CMD_GEN     = 2'd1,
        CMD_MIX     = 2'd2,
        CMD_UNIFORM = 2'd3
    } cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEED,
        ST_GEN1,
        ST_GEN2,
        ST_MIX,
        ST_THR,
        ST_SDIV,
        ST_DRAIN
    } state_t;

endpackage

FILE: src/ccdrbg_block_unit.sv
// ----------------------------------------------------------------------------
// ccdrbg_block_unit
// ChaCha20 block function on one shared half quarter-round datapath.
// ----------------------------------------------------------------------------
module ccdrbg_block_unit (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  logic [255:0] key,
    input  logic [31:0]  counter,
    input  logic [95:0]  nonce,
    output logic         done,
    output logic [511:0] result
);

    localparam int unsigned CW = $clog2(ccdrbg_pkg::ROUND_STEPS);

    ccdrbg_pkg::word_t x_reg    [16];
    ccdrbg_pkg::word_t init_reg [16];
    ccdrbg_pkg::word_t q        [16];
    ccdrbg_pkg::word_t p        [16];
    logic [CW-1:0]     cnt_reg;
    logic              busy_reg;
    logic              fin_reg;
    logic              done_reg;
    logic [511:0]      res_reg;
    logic [2:0]        qi;
    ccdrbg_pkg::word_t a1, d1, c1, b1;

    assign qi = cnt_reg[3:1];

    // half quarter round on column zero (lanes 0, 4, 8, 12)
    always_comb begin
        for (int i = 0; i < 16; i++) q[i] = x_reg[i];
        if (!cnt_reg[0]) begin
            a1 = x_reg[0] + x_reg[4];
            d1 = x_reg[12] ^ a1;
            d1 = {d1[15:0], d1[31:16]};
            c1 = x_reg[8] + d1;
            b1 = x_reg[4] ^ c1;
            b1 = {b1[19:0], b1[31:20]};
        end else begin
            a1 = x_reg[0] + x_reg[4];
            d1 = x_reg[12] ^ a1;
            d1 = {d1[23:0], d1[31:24]};
            c1 = x_reg[8] + d1;
            b1 = x_reg[4] ^ c1;
            b1 = {b1[24:0], b1[31:25]};
        end
        q[0]  = a1;
        q[4]  = b1;
        q[8]  = c1;
        q[12] = d1;
    end

    // after a full quarter round rotate rows: next column into lane zero,
    // diagonalize after the column round, undo it after the diagonal round
    always_comb begin
        logic [1:0] sh;
        for (int r = 0; r < 4; r++) begin
            if (qi == 3'd3) begin
                sh = 2'(1 + r);
            end else if (qi == 3'd7) begin
                sh = 2'(5 - r);
            end else begin
                sh = 2'd1;
            end
            for (int c = 0; c < 4; c++) begin
                p[r*4+c] = cnt_reg[0] ? q[r*4 + int'(2'(2'(c) + sh))] : q[r*4+c];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            fin_reg  <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(ccdrbg_pkg::ROUND_STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
            end else if (fin_reg) begin
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            init_reg[0]  <= ccdrbg_pkg::SIGMA0;
            init_reg[1]  <= ccdrbg_pkg::SIGMA1;
            init_reg[2]  <= ccdrbg_pkg::SIGMA2;
            init_reg[3]  <= ccdrbg_pkg::SIGMA3;
            x_reg[0]     <= ccdrbg_pkg::SIGMA0;
            x_reg[1]     <= ccdrbg_pkg::SIGMA1;
            x_reg[2]     <= ccdrbg_pkg::SIGMA2;
            x_reg[3]     <= ccdrbg_pkg::SIGMA3;
            for (int i = 0; i < 8; i++) begin
                init_reg[4+i] <= key[32*i +: 32];
                x_reg[4+i]    <= key[32*i +: 32];
            end
            init_reg[12] <= counter;
            x_reg[12]    <= counter;
            for (int i = 0; i < 3; i++) begin
                init_reg[13+i] <= nonce[32*i +: 32];
                x_reg[13+i]    <= nonce[32*i +: 32];
            end
        end else if (busy_reg) begin
            for (int i = 0; i < 16; i++) x_reg[i] <= p[i];
        end
        if (fin_reg) begin
            for (int i = 0; i < 16; i++) res_reg[32*i +: 32] <= x_reg[i] + init_reg[i];
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

FILE: src/ccdrbg_mod_unit.sv
// ----------------------------------------------------------------------------
// ccdrbg_mod_unit
// Bit-serial 64-bit remainder, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module ccdrbg_mod_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [63:0] divisor,
    output logic        done,
    output logic [63:0] remainder
);

    logic [63:0] rem_reg;
    logic [63:0] dvd_reg;
    logic [63:0] dvs_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [64:0] trial;
    logic [64:0] diff;

    assign trial = {rem_reg, dvd_reg[63]};
    assign diff  = trial - {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == 6'd63) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            dvd_reg <= dividend;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            // restoring step: keep the difference when it does not borrow
            rem_reg <= diff[64] ? trial[63:0] : diff[63:0];
            dvd_reg <= {dvd_reg[62:0], 1'b0};
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

FILE: src/chacha20_drbg_engine_core.sv
// ----------------------------------------------------------------------------
// chacha20_drbg_engine_core
// ChaCha20 random generator with fast key erasure: seed, generate, mix and
// uniform commands over one shared block unit and one serial modulo unit.
// ----------------------------------------------------------------------------
// One command is taken at a time; s_tready is high only while the engine is
// idle and no result is pending. Every ChaCha20 block runs on a single half
// quarter-round datapath: the rounds, then the final add and hand-off.
// Seed and a non-empty mix take one block, generate two blocks and then
// eight result items, one per cycle when m_tready stays high. Uniform first
// computes its rejection threshold on the bit-serial modulo unit (64 steps
// plus start and hand-off), then runs one generate step (two blocks) per
// try, and runs the modulo unit once more for the final remainder; at most
// UNIFORM_TRIES tries. Failures known at accept time (not seeded, zero
// bound) answer in the cycle after the accept.
// ----------------------------------------------------------------------------
module chacha20_drbg_engine_core #(
    parameter int unsigned UNIFORM_TRIES = 128
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // word0[63:0], word1, word2, word3, word4, word5, chunk_length[5:0],
    // upper_bound[63:0], two zero pad bits
    input  logic [455:0] s_tdata,
    // cmd[1:0]
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // random_word[63:0], word_index[2:0], five zero pad bits
    output logic [71:0]  m_tdata,
    output logic         m_tlast,
    // ok
    output logic         m_tuser
);

    localparam int unsigned TW = $clog2(UNIFORM_TRIES) + 1;

    ccdrbg_pkg::state_t state_reg, state_next;

    // secret state
    logic [255:0] key_reg, key_next;
    logic [95:0]  nonce_reg, nonce_next;
    logic [31:0]  ctr_reg, ctr_next;
    logic         ready_reg, ready_next;

    // captured command
    ccdrbg_pkg::cmd_t cmd_reg, cmd_next;
    logic [255:0] chunk_reg, chunk_next;
    logic [5:0]   len_reg, len_next;
    logic [63:0]  bound_reg, bound_next;
    logic [63:0]  thr_reg, thr_next;
    logic [511:0] outblk_reg, outblk_next;
    logic [TW-1:0] try_reg, try_next;
    logic         emit_blk_reg, emit_blk_next;

    // result register
    logic         mval_reg, mval_next;
    logic [63:0]  mword_reg, mword_next;
    logic [2:0]   midx_reg, midx_next;
    logic         mlast_reg, mlast_next;
    logic         mok_reg, mok_next;

    logic         blk_start_reg, blk_start_next;
    logic         div_start_reg, div_start_next;

    logic         blk_done;
    logic [511:0] blk_res;
    logic         div_done;
    logic [63:0]  div_rem;
    logic [63:0]  div_dividend;

    logic         s_fire;
    logic         m_fire;
    logic [127:0] bumped;
    logic         bump_ok;
    logic [5:0]   in_len;
    logic [255:0] chunk_mask;
    logic [63:0]  sample;
    ccdrbg_pkg::cmd_t in_cmd;

    assign s_fire  = s_tvalid && s_tready;
    assign m_fire  = mval_reg && m_tready;
    assign in_cmd  = ccdrbg_pkg::cmd_t'(s_tuser);
    // saturate the mix length at 32 bytes
    assign in_len  = (s_tdata[389:384] > 6'(ccdrbg_pkg::MAX_CHUNK)) ?
                     6'(ccdrbg_pkg::MAX_CHUNK) : s_tdata[389:384];
    // counter first, then nonce words 0..2 as carry chain
    assign bumped  = {nonce_reg, ctr_reg} + 128'd1;
    assign bump_ok = |bumped;
    assign sample  = outblk_reg[63:0];
    assign div_dividend = (state_reg == ccdrbg_pkg::ST_THR) ? (64'd0 - bound_reg) : sample;

    always_comb begin
        for (int i = 0; i < 32; i++) begin
            chunk_mask[8*i +: 8] = (6'(i) < len_reg) ? 8'hFF : 8'h00;
        end
    end

    ccdrbg_block_unit u_block (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (blk_start_reg),
        .key     (key_reg),
        .counter (ctr_reg),
        .nonce   (nonce_reg),
        .done    (blk_done),
        .result  (blk_res)
    );

    ccdrbg_mod_unit u_mod (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start_reg),
        .dividend  (div_dividend),
        .divisor   (bound_reg),
        .done      (div_done),
        .remainder (div_rem)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ccdrbg_pkg::ST_IDLE: begin
                if (s_fire) begin
                    unique case (in_cmd)
                        ccdrbg_pkg::CMD_SEED:
                            state_next = ccdrbg_pkg::ST_SEED;
                        ccdrbg_pkg::CMD_GEN:
                            state_next = ready_reg ? ccdrbg_pkg::ST_GEN1
                                                   : ccdrbg_pkg::ST_DRAIN;
                        ccdrbg_pkg::CMD_MIX:
                            state_next = (ready_reg && in_len != 6'd0) ?
                                         ccdrbg_pkg::ST_MIX : ccdrbg_pkg::ST_DRAIN;
                        ccdrbg_pkg::CMD_UNIFORM:
                            state_next = (ready_reg && s_tdata[453:390] != 64'd0) ?
                                         ccdrbg_pkg::ST_THR : ccdrbg_pkg::ST_DRAIN;
                        default:
                            state_next = ccdrbg_pkg::ST_DRAIN;
                    endcase
                end
            end
            ccdrbg_pkg::ST_SEED, ccdrbg_pkg::ST_MIX: begin
                if (blk_done) state_next = ccdrbg_pkg::ST_DRAIN;
            end
            ccdrbg_pkg::ST_GEN1: begin
                if (blk_done) state_next = bump_ok ? ccdrbg_pkg::ST_GEN2
                                                   : ccdrbg_pkg::ST_DRAIN;
            end
            ccdrbg_pkg::ST_GEN2: begin
                if (blk_done) begin
                    if (!bump_ok || cmd_reg == ccdrbg_pkg::CMD_GEN) begin
                        state_next = ccdrbg_pkg::ST_DRAIN;
                    end else if (sample >= thr_reg) begin
                        state_next = ccdrbg_pkg::ST_SDIV;
                    end else if (try_reg == TW'(UNIFORM_TRIES - 1)) begin
                        state_next = ccdrbg_pkg::ST_DRAIN;
                    end else begin
                        state_next = ccdrbg_pkg::ST_GEN1;
                    end
                end
            end
            ccdrbg_pkg::ST_THR: begin
                if (div_done) state_next = ccdrbg_pkg::ST_GEN1;
            end
            ccdrbg_pkg::ST_SDIV: begin
                if (div_done) state_next = ccdrbg_pkg::ST_DRAIN;
            end
            ccdrbg_pkg::ST_DRAIN: begin
                if (m_fire && !(emit_blk_reg && midx_reg != 3'd7)) begin
                    state_next = ccdrbg_pkg::ST_IDLE;
                end
            end
            default: state_next = ccdrbg_pkg::ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        key_next       = key_reg;
        nonce_next     = nonce_reg;
        ctr_next       = ctr_reg;
        ready_next     = ready_reg;
        cmd_next       = cmd_reg;
        chunk_next     = chunk_reg;
        len_next       = len_reg;
        bound_next     = bound_reg;
        thr_next       = thr_reg;
        outblk_next    = outblk_reg;
        try_next       = try_reg;
        emit_blk_next  = emit_blk_reg;
        mval_next      = mval_reg;
        mword_next     = mword_reg;
        midx_next      = midx_reg;
        mlast_next     = mlast_reg;
        mok_next       = mok_reg;
        blk_start_next = 1'b0;
        div_start_next = 1'b0;

        unique case (state_reg)
            ccdrbg_pkg::ST_IDLE: begin
                if (s_fire) begin
                    cmd_next      = in_cmd;
                    chunk_next    = s_tdata[255:0];
                    len_next      = in_len;
                    bound_next    = s_tdata[453:390];
                    try_next      = '0;
                    emit_blk_next = 1'b0;
                    // default answer: single failing item
                    mword_next    = '0;
                    midx_next     = '0;
                    mlast_next    = 1'b1;
                    mok_next      = 1'b0;
                    unique case (in_cmd)
                        ccdrbg_pkg::CMD_SEED: begin
                            key_next       = s_tdata[255:0];
                            nonce_next     = s_tdata[351:256];
                            ctr_next       = s_tdata[383:352];
                            blk_start_next = 1'b1;
                        end
                        ccdrbg_pkg::CMD_GEN: begin
                            blk_start_next = ready_reg;
                            mval_next      = !ready_reg;
                        end
                        ccdrbg_pkg::CMD_MIX: begin
                            if (in_len == 6'd0) begin
                                mok_next  = ready_reg;
                                mval_next = 1'b1;
                            end else begin
                                blk_start_next = ready_reg;
                                mval_next      = !ready_reg;
                            end
                        end
                        ccdrbg_pkg::CMD_UNIFORM: begin
                            if (ready_reg && s_tdata[453:390] != 64'd0) begin
                                div_start_next = 1'b1;
                            end else begin
                                mval_next = 1'b1;
                            end
                        end
                        default: mval_next = 1'b1;
                    endcase
                end
            end
            ccdrbg_pkg::ST_SEED: begin
                if (blk_done) begin
                    key_next   = blk_res[255:0];
                    nonce_next = blk_res[351:256];
                    ctr_next   = blk_res[383:352];
                    ready_next = 1'b1;
                    mok_next   = 1'b1;
                    mval_next  = 1'b1;
                end
            end
            ccdrbg_pkg::ST_MIX: begin
                if (blk_done) begin
                    mval_next = 1'b1;
                    if (!bump_ok) begin
                        {nonce_next, ctr_next} = bumped;
                        ready_next = 1'b0;
                    end else begin
                        key_next   = blk_res[255:0] ^ (chunk_reg & chunk_mask);
                        nonce_next = blk_res[351:256];
                        ctr_next   = blk_res[383:352] ^
                                     {2'b00, len_reg, ccdrbg_pkg::TAG_B2,
                                      ccdrbg_pkg::TAG_B1, ccdrbg_pkg::TAG_B0};
                        mok_next   = 1'b1;
                    end
                end
            end
            ccdrbg_pkg::ST_GEN1: begin
                if (blk_done) begin
                    outblk_next            = blk_res;
                    {nonce_next, ctr_next} = bumped;
                    if (!bump_ok) begin
                        ready_next = 1'b0;
                        mval_next  = 1'b1;
                    end else begin
                        blk_start_next = 1'b1;
                    end
                end
            end
            ccdrbg_pkg::ST_GEN2: begin
                if (blk_done) begin
                    if (!bump_ok) begin
                        {nonce_next, ctr_next} = bumped;
                        ready_next = 1'b0;
                        mval_next  = 1'b1;
                    end else begin
                        // fast key erasure: next block replaces the state
                        key_next   = blk_res[255:0];
                        nonce_next = blk_res[351:256];
                        ctr_next   = blk_res[383:352];
                        if (cmd_reg == ccdrbg_pkg::CMD_GEN) begin
                            emit_blk_next = 1'b1;
                            mword_next    = outblk_reg[63:0];
                            midx_next     = 3'd0;
                            mlast_next    = 1'b0;
                            mok_next      = 1'b1;
                            mval_next     = 1'b1;
                        end else if (sample >= thr_reg) begin
                            div_start_next = 1'b1;
                        end else if (try_reg == TW'(UNIFORM_TRIES - 1)) begin
                            mval_next = 1'b1;
                        end else begin
                            try_next       = try_reg + 1'b1;
                            blk_start_next = 1'b1;
                        end
                    end
                end
            end
            ccdrbg_pkg::ST_THR: begin
                if (div_done) begin
                    thr_next       = div_rem;
                    blk_start_next = 1'b1;
                end
            end
            ccdrbg_pkg::ST_SDIV: begin
                if (div_done) begin
                    mword_next = div_rem;
                    mok_next   = 1'b1;
                    mval_next  = 1'b1;
                end
            end
            ccdrbg_pkg::ST_DRAIN: begin
                if (m_fire) begin
                    if (emit_blk_reg && midx_reg != 3'd7) begin
                        // advance to the next word of the exported block
                        midx_next  = midx_reg + 3'd1;
                        mword_next = outblk_reg[64*(midx_reg + 3'd1) +: 64];
                        mlast_next = (midx_reg == 3'd6);
                    end else begin
                        mval_next = 1'b0;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ccdrbg_pkg::ST_IDLE;
            key_reg       <= '0;
            nonce_reg     <= '0;
            ctr_reg       <= '0;
            ready_reg     <= 1'b0;
            mval_reg      <= 1'b0;
            blk_start_reg <= 1'b0;
            div_start_reg <= 1'b0;
            emit_blk_reg  <= 1'b0;
            try_reg       <= '0;
        end else begin
            state_reg     <= state_next;
            key_reg       <= key_next;
            nonce_reg     <= nonce_next;
            ctr_reg       <= ctr_next;
            ready_reg     <= ready_next;
            mval_reg      <= mval_next;
            blk_start_reg <= blk_start_next;
            div_start_reg <= div_start_next;
            emit_blk_reg  <= emit_blk_next;
            try_reg       <= try_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg    <= cmd_next;
        chunk_reg  <= chunk_next;
        len_reg    <= len_next;
        bound_reg  <= bound_next;
        thr_reg    <= thr_next;
        outblk_reg <= outblk_next;
        mword_reg  <= mword_next;
        midx_reg   <= midx_next;
        mlast_reg  <= mlast_next;
        mok_reg    <= mok_next;
    end

    assign s_tready = (state_reg == ccdrbg_pkg::ST_IDLE);
    assign m_tvalid = mval_reg;
    assign m_tdata  = {5'd0, midx_reg, mword_reg};
    assign m_tlast  = mlast_reg;
    assign m_tuser  = mok_reg;

endmodule
